// ===== rtl/v3a_pkg.sv =====
`default_nettype none

package v3a_pkg;

    // Coordinate and result formats
    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 8;
    localparam int SCALAR_W = 64;

    // Square root and division datapath sizes
    localparam int ROOT_W = 24;              // floor(sqrt(u.u * 2^16)) < 2^24
    localparam int RAD_W  = 48;              // radicand u.u with 2*FRAC_W fraction bits
    localparam int SREM_W = 27;              // root remainder after the pair shift
    localparam int VV_W   = 32;              // v.v < 2^32
    localparam int QUO_W  = 24;              // projection quotient bits
    localparam int DREM_W = 33;              // division remainder after the bit shift
    localparam int N_ITER = 12;              // two root and two quotient bits per stage
    localparam int LANES  = 3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [2:0] {
        OP_MAG    = 3'd0,
        OP_SCALE  = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_PROJ   = 3'd4,
        OP_DOT    = 3'd5,
        OP_CROSS  = 3'd6,
        OP_TRIPLE = 3'd7
    } t_op;

    typedef struct packed {
        t_coord                     x;
        t_coord                     y;
        t_coord                     z;
        logic signed [SCALAR_W-1:0] scalar;
        logic                       zero;
        logic                       status;
        logic                       sat;
    } t_res;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
    } t_lane;

    typedef struct packed {
        t_op                     op;
        t_res                    res;
        logic [RAD_W-1:0]        rad;
        logic [SREM_W-1:0]       srem;
        logic [ROOT_W-1:0]       root;
        logic [VV_W-1:0]         vv;
        t_lane [LANES-1:0]       lane;
        logic [LANES-1:0]        cneg;
        logic [LANES-1:0]        presat;
        logic                    vzero;
    } t_iter;

endpackage

`default_nettype wire

// ===== rtl/v3a_front.sv =====
`default_nettype none

module v3a_front
    import v3a_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_op    i_op,
    input  wire t_coord i_u [LANES],
    input  wire t_coord i_v [LANES],
    input  wire t_coord i_w [LANES],
    input  wire t_coord i_s,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_iter       o_item
);

    localparam logic signed [39:0] HALF = 40'sd1 <<< (FRAC_W - 1);

    typedef struct packed {
        t_coord val;
        logic   sat;
    } t_clip;

    // Saturate a wide value to the coordinate range
    function automatic t_clip clip_coord(input logic signed [39:0] x);
        t_clip c;
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = (40'sd1 <<< (COORD_W - 1)) - 40'sd1;
        lo = -hi - 40'sd1;
        c.sat = 1'b0;
        c.val = COORD_W'(x);
        if (x > hi) begin
            c.sat = 1'b1;
            c.val = COORD_W'(hi);
        end else if (x < lo) begin
            c.sat = 1'b1;
            c.val = COORD_W'(lo);
        end
        return c;
    endfunction

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic a_ready, b_ready, c_ready, d_ready;

    // Stage ready chain: a stage takes an item when empty or when it moves on
    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_d_valid;

    //------------------------------------------------------------------
    // Stage A: all first-level products
    //------------------------------------------------------------------
    t_coord            opa [LANES];
    t_coord            opb [LANES];
    logic signed [31:0] n_a_pd  [LANES];
    logic signed [31:0] n_a_pv  [LANES];
    logic signed [31:0] n_a_pxp [LANES];
    logic signed [31:0] n_a_pxn [LANES];
    logic signed [31:0] n_a_ps  [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            opa[i] = (i_op == OP_TRIPLE) ? i_v[i] : i_u[i];
            opb[i] = (i_op == OP_TRIPLE) ? i_w[i] : ((i_op == OP_MAG) ? i_u[i] : i_v[i]);
        end
        for (int i = 0; i < LANES; i++) begin
            n_a_pd[i] = opa[i] * opb[i];
            n_a_pv[i] = i_v[i] * i_v[i];
            n_a_ps[i] = i_u[i] * i_s;
        end
        n_a_pxp[0] = opa[1] * opb[2];
        n_a_pxn[0] = opa[2] * opb[1];
        n_a_pxp[1] = opa[2] * opb[0];
        n_a_pxn[1] = opa[0] * opb[2];
        n_a_pxp[2] = opa[0] * opb[1];
        n_a_pxn[2] = opa[1] * opb[0];
    end

    t_op                r_a_op;
    logic signed [31:0] r_a_pd  [LANES];
    logic signed [31:0] r_a_pv  [LANES];
    logic signed [31:0] r_a_pxp [LANES];
    logic signed [31:0] r_a_pxn [LANES];
    logic signed [31:0] r_a_ps  [LANES];
    t_coord             r_a_u   [LANES];
    t_coord             r_a_v   [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_op  <= i_op;
            r_a_pd  <= n_a_pd;
            r_a_pv  <= n_a_pv;
            r_a_pxp <= n_a_pxp;
            r_a_pxn <= n_a_pxn;
            r_a_ps  <= n_a_ps;
            r_a_u   <= i_u;
            r_a_v   <= i_v;
        end
    end

    //------------------------------------------------------------------
    // Stage B: sums, cross components, rounded vector results
    //------------------------------------------------------------------
    logic signed [33:0]  n_b_dot;
    logic [VV_W-1:0]     n_b_vv;
    logic signed [32:0]  n_b_c [LANES];
    t_clip               cl [LANES];
    t_res                n_b_res;

    always_comb begin
        n_b_dot = 34'(r_a_pd[0]) + 34'(r_a_pd[1]) + 34'(r_a_pd[2]);
        n_b_vv  = $unsigned(r_a_pv[0]) + $unsigned(r_a_pv[1]) + $unsigned(r_a_pv[2]);
        for (int i = 0; i < LANES; i++) begin
            n_b_c[i] = 33'(r_a_pxp[i]) - 33'(r_a_pxn[i]);
        end
        for (int i = 0; i < LANES; i++) begin
            cl[i] = '0;
        end
        n_b_res = '0;
        unique case (r_a_op)
            OP_SCALE: begin
                for (int i = 0; i < LANES; i++) begin
                    cl[i] = clip_coord((40'(r_a_ps[i]) + HALF) >>> FRAC_W);
                end
            end
            OP_ADD: begin
                for (int i = 0; i < LANES; i++) begin
                    cl[i] = clip_coord(40'(r_a_u[i]) + 40'(r_a_v[i]));
                end
            end
            OP_SUB: begin
                for (int i = 0; i < LANES; i++) begin
                    cl[i] = clip_coord(40'(r_a_u[i]) - 40'(r_a_v[i]));
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < LANES; i++) begin
                    cl[i] = clip_coord((40'(n_b_c[i]) + HALF) >>> FRAC_W);
                end
                n_b_res.zero = (n_b_c[0] == '0) && (n_b_c[1] == '0) && (n_b_c[2] == '0);
            end
            OP_DOT: begin
                n_b_res.scalar = SCALAR_W'(n_b_dot) <<< FRAC_W;
                n_b_res.zero   = (n_b_dot == '0);
            end
            OP_MAG, OP_PROJ, OP_TRIPLE: begin
            end
        endcase
        n_b_res.x   = cl[0].val;
        n_b_res.y   = cl[1].val;
        n_b_res.z   = cl[2].val;
        n_b_res.sat = cl[0].sat | cl[1].sat | cl[2].sat;
    end

    t_op                r_b_op;
    t_res               r_b_res;
    logic signed [33:0] r_b_dot;
    logic [VV_W-1:0]    r_b_vv;
    logic signed [32:0] r_b_c [LANES];
    t_coord             r_b_u [LANES];
    t_coord             r_b_v [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_op  <= r_a_op;
            r_b_res <= n_b_res;
            r_b_dot <= n_b_dot;
            r_b_vv  <= n_b_vv;
            r_b_c   <= n_b_c;
            r_b_u   <= r_a_u;
            r_b_v   <= r_a_v;
        end
    end

    //------------------------------------------------------------------
    // Stage C: triple terms and projection numerators
    //------------------------------------------------------------------
    logic [31:0]        n_c_mag;
    logic [15:0]        vm [LANES];
    logic [47:0]        n_c_pm [LANES];
    logic signed [48:0] n_c_t  [LANES];
    logic [LANES-1:0]   n_c_cneg;

    always_comb begin
        n_c_mag = r_b_dot[33] ? 32'(-r_b_dot) : 32'(r_b_dot);
        for (int i = 0; i < LANES; i++) begin
            vm[i]       = r_b_v[i][COORD_W-1] ? 16'(-r_b_v[i]) : 16'(r_b_v[i]);
            n_c_pm[i]   = vm[i] * n_c_mag;
            n_c_t[i]    = r_b_c[i] * r_b_u[i];
            n_c_cneg[i] = r_b_v[i][COORD_W-1] ^ r_b_dot[33];
        end
    end

    t_op                r_c_op;
    t_res               r_c_res;
    logic [VV_W-1:0]    r_c_vv;
    logic [31:0]        r_c_mag;
    logic [47:0]        r_c_pm [LANES];
    logic signed [48:0] r_c_t  [LANES];
    logic [LANES-1:0]   r_c_cneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_op   <= r_b_op;
            r_c_res  <= r_b_res;
            r_c_vv   <= r_b_vv;
            r_c_mag  <= n_c_mag;
            r_c_pm   <= n_c_pm;
            r_c_t    <= n_c_t;
            r_c_cneg <= n_c_cneg;
        end
    end

    //------------------------------------------------------------------
    // Stage D: triple sum, divider and root setup
    //------------------------------------------------------------------
    logic signed [50:0] trip;
    logic [47:0]        num [LANES];
    t_iter              n_d_item;

    always_comb begin
        trip = 51'(r_c_t[0]) + 51'(r_c_t[1]) + 51'(r_c_t[2]);
        n_d_item       = '0;
        n_d_item.op    = r_c_op;
        n_d_item.res   = r_c_res;
        n_d_item.rad   = {r_c_mag, {(2*FRAC_W){1'b0}}};
        n_d_item.vv    = r_c_vv;
        n_d_item.vzero = (r_c_vv == '0);
        n_d_item.cneg  = r_c_cneg;
        if (r_c_op == OP_TRIPLE) begin
            n_d_item.res.scalar = SCALAR_W'(trip);
            n_d_item.res.zero   = (trip == '0);
        end
        for (int i = 0; i < LANES; i++) begin
            num[i] = r_c_pm[i] + 48'(r_c_vv >> 1);
            n_d_item.presat[i]   = (32'(num[i][47:QUO_W]) >= r_c_vv);
            n_d_item.lane[i].rem = DREM_W'(num[i][47:QUO_W]);
            n_d_item.lane[i].low = num[i][QUO_W-1:0];
            n_d_item.lane[i].quo = '0;
        end
    end

    t_iter r_d_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready && r_c_valid) begin
            r_d_item <= n_d_item;
        end
    end

    assign o_item = r_d_item;

endmodule

`default_nettype wire

// ===== rtl/v3a_iter.sv =====
`default_nettype none

module v3a_iter
    import v3a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_iter i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_iter      o_item
);

    t_iter             n_item;
    logic [SREM_W-1:0] sq;
    logic [SREM_W-1:0] trial;
    logic [DREM_W-1:0] dr;
    logic [DREM_W-1:0] dv;

    // Two root digits and two quotient bits per lane
    always_comb begin
        n_item = i_item;
        dv     = DREM_W'(i_item.vv);
        sq     = '0;
        trial  = '0;
        dr     = '0;
        for (int k = 0; k < 2; k++) begin
            sq    = {n_item.srem[SREM_W-3:0], n_item.rad[RAD_W-1 -: 2]};
            trial = {1'b0, n_item.root, 2'b01};
            if (sq >= trial) begin
                n_item.srem = sq - trial;
                n_item.root = {n_item.root[ROOT_W-2:0], 1'b1};
            end else begin
                n_item.srem = sq;
                n_item.root = {n_item.root[ROOT_W-2:0], 1'b0};
            end
            n_item.rad = n_item.rad << 2;
            for (int l = 0; l < LANES; l++) begin
                dr = {n_item.lane[l].rem[DREM_W-2:0], n_item.lane[l].low[QUO_W-1]};
                if (dr >= dv) begin
                    n_item.lane[l].rem = dr - dv;
                    n_item.lane[l].quo = {n_item.lane[l].quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_item.lane[l].rem = dr;
                    n_item.lane[l].quo = {n_item.lane[l].quo[QUO_W-2:0], 1'b0};
                end
                n_item.lane[l].low = n_item.lane[l].low << 1;
            end
        end
    end

    logic  r_valid;
    t_iter r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/v3a_back.sv =====
`default_nettype none

module v3a_back
    import v3a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_iter i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_res       o_res
);

    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(1) << (COORD_W - 1);
    localparam logic [QUO_W-1:0] LIM_POS = LIM_NEG - QUO_W'(1);

    t_res             n_res;
    logic [QUO_W-1:0] lim [LANES];
    logic [QUO_W-1:0] q   [LANES];
    t_coord           pv  [LANES];
    logic [LANES-1:0] psat;

    // Finish magnitude and projection, pass the rest
    always_comb begin
        n_res = i_item.res;
        for (int i = 0; i < LANES; i++) begin
            lim[i]  = i_item.cneg[i] ? LIM_NEG : LIM_POS;
            psat[i] = i_item.presat[i] || (i_item.lane[i].quo > lim[i]);
            q[i]    = psat[i] ? lim[i] : i_item.lane[i].quo;
            pv[i]   = COORD_W'(i_item.cneg[i] ? -q[i] : q[i]);
        end
        unique case (i_item.op)
            OP_MAG: begin
                n_res.scalar = SCALAR_W'({i_item.root, {FRAC_W{1'b0}}});
            end
            OP_PROJ: begin
                if (i_item.vzero) begin
                    n_res.status = 1'b1;
                end else begin
                    n_res.x   = pv[0];
                    n_res.y   = pv[1];
                    n_res.z   = pv[2];
                    n_res.sat = |psat;
                end
            end
            default: begin
            end
        endcase
    end

    logic r_valid;
    t_res r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vector3_alu.sv =====
// 3-D vector ALU on signed Q8.8 coordinates.
// Input channel: i_valid / o_stall carry one item (opcode, vectors u, v, w and
// a scale factor); an item is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carry one result item (vector
// in Q8.8, scalar in Q40.24, zero, status and saturation flags).
// The pipeline holds four stages of products and sums, twelve stages of the
// square root and projection divider (two digits per stage, 24 in all), and
// the output register. The root and divider stages set the depth.
// Throughput is one item per cycle while i_stall is low; every stage holds one item.
// A stalled receiver holds the output register; earlier stages keep filling
// until each one holds an item, then o_stall rises. Nothing is dropped or
// repeated.
// Reset (synchronous, active low) empties every stage; no clearing pass.
`default_nettype none

module vector3_alu
    import v3a_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [2:0]                 i_req_type,
    input  wire logic signed [COORD_W-1:0]  i_u_x,
    input  wire logic signed [COORD_W-1:0]  i_u_y,
    input  wire logic signed [COORD_W-1:0]  i_u_z,
    input  wire logic signed [COORD_W-1:0]  i_v_x,
    input  wire logic signed [COORD_W-1:0]  i_v_y,
    input  wire logic signed [COORD_W-1:0]  i_v_z,
    input  wire logic signed [COORD_W-1:0]  i_w_x,
    input  wire logic signed [COORD_W-1:0]  i_w_y,
    input  wire logic signed [COORD_W-1:0]  i_w_z,
    input  wire logic signed [COORD_W-1:0]  i_scale_factor,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [COORD_W-1:0]       o_res_x,
    output logic signed [COORD_W-1:0]       o_res_y,
    output logic signed [COORD_W-1:0]       o_res_z,
    output logic signed [SCALAR_W-1:0]      o_res_scalar,
    output logic                            o_is_zero,
    output logic                            o_status,
    output logic                            o_saturated
);

    t_coord u [LANES];
    t_coord v [LANES];
    t_coord w [LANES];

    assign u[0] = i_u_x;
    assign u[1] = i_u_y;
    assign u[2] = i_u_z;
    assign v[0] = i_v_x;
    assign v[1] = i_v_y;
    assign v[2] = i_v_z;
    assign w[0] = i_w_x;
    assign w[1] = i_w_y;
    assign w[2] = i_w_z;

    logic  vld  [N_ITER+1];
    logic  rdy  [N_ITER+1];
    t_iter item [N_ITER+1];
    logic  in_ready;
    t_res  res;

    // Products, sums and divider setup
    v3a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (in_ready),
        .i_op    (t_op'(i_req_type)),
        .i_u     (u),
        .i_v     (v),
        .i_w     (w),
        .i_s     (i_scale_factor),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_item  (item[0])
    );

    // Root and quotient digit stages
    for (genvar g = 0; g < N_ITER; g++) begin : g_iter
        v3a_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .o_ready (rdy[g]),
            .i_item  (item[g]),
            .o_valid (vld[g+1]),
            .i_ready (rdy[g+1]),
            .o_item  (item[g+1])
        );
    end

    // Result assembly and output register
    v3a_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld[N_ITER]),
        .o_ready (rdy[N_ITER]),
        .i_item  (item[N_ITER]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_res   (res)
    );

    assign o_stall      = !in_ready;
    assign o_res_x      = res.x;
    assign o_res_y      = res.y;
    assign o_res_z      = res.z;
    assign o_res_scalar = res.scalar;
    assign o_is_zero    = res.zero;
    assign o_status     = res.status;
    assign o_saturated  = res.sat;

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An empty output register lets every stage move
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // Projection onto zero returns the zero vector without clipping
    a_status_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |->
            o_res_x == '0 && o_res_y == '0 && o_res_z == '0 && !o_saturated)
        else $error("bad zero-vector projection result");

    // A zero flag never comes with a nonzero scalar
    a_zero_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_zero |-> o_res_scalar == '0)
        else $error("zero flag with nonzero scalar");

    // Clipping happens only on vector operations
    a_sat_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_res_scalar == '0)
        else $error("saturation on scalar result");

endmodule

`default_nettype wire

// ===== sim/vector3_alu_checker.sv =====
`default_nettype none

module vector3_alu_checker
    import v3a_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       i_stall_in,
    input  wire logic [2:0]                 i_req_type,
    input  wire logic signed [COORD_W-1:0]  i_u_x,
    input  wire logic signed [COORD_W-1:0]  i_u_y,
    input  wire logic signed [COORD_W-1:0]  i_u_z,
    input  wire logic signed [COORD_W-1:0]  i_v_x,
    input  wire logic signed [COORD_W-1:0]  i_v_y,
    input  wire logic signed [COORD_W-1:0]  i_v_z,
    input  wire logic signed [COORD_W-1:0]  i_w_x,
    input  wire logic signed [COORD_W-1:0]  i_w_y,
    input  wire logic signed [COORD_W-1:0]  i_w_z,
    input  wire logic signed [COORD_W-1:0]  i_scale_factor,
    input  wire logic                       i_res_valid,
    input  wire logic                       i_res_stall,
    input  wire logic signed [COORD_W-1:0]  i_res_x,
    input  wire logic signed [COORD_W-1:0]  i_res_y,
    input  wire logic signed [COORD_W-1:0]  i_res_z,
    input  wire logic signed [SCALAR_W-1:0] i_res_scalar,
    input  wire logic                       i_is_zero,
    input  wire logic                       i_status,
    input  wire logic                       i_saturated,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_res expected_q[$];

    // Saturate to the coordinate range, raising the flag on a clip
    function automatic longint clamp_coord(longint x, inout logic sat);
        if (x > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (x < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return x;
    endfunction

    // Drop FRAC_W fraction bits, ties toward +infinity
    function automatic longint round_q8(longint x);
        return (x + 128) >>> 8;
    endfunction

    // Integer square root, bit by bit
    function automatic longint unsigned isqrt(longint unsigned r);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > r) bitv >>= 2;
        while (bitv != 0) begin
            if (r >= root + bitv) begin
                r -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_res predict_vector_op(t_op op, longint u[3], longint v[3],
                                               longint w[3], longint s);
        t_res r;
        longint c[3];
        longint o[3];
        longint d;
        longint vv;
        longint unsigned m;
        longint unsigned q;
        longint unsigned vm;
        longint unsigned lim;
        logic sat;
        logic cneg;
        sat = 1'b0;
        o = '{0, 0, 0};
        r = '0;
        case (op)
            OP_MAG: begin
                // u.u < 2^33, so shifting by 16 stays in range
                m = longint'(u[0]*u[0] + u[1]*u[1] + u[2]*u[2]);
                r.scalar = isqrt(m << 16) << 8;
            end
            OP_SCALE: for (int i = 0; i < 3; i++) o[i] = clamp_coord(round_q8(u[i]*s), sat);
            OP_ADD: for (int i = 0; i < 3; i++) o[i] = clamp_coord(u[i] + v[i], sat);
            OP_SUB: for (int i = 0; i < 3; i++) o[i] = clamp_coord(u[i] - v[i], sat);
            OP_PROJ: begin
                vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
                if (vv == 0) begin
                    r.status = 1'b1;
                end else begin
                    d = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
                    m = (d < 0) ? -d : d;
                    for (int i = 0; i < 3; i++) begin
                        vm = (v[i] < 0) ? -v[i] : v[i];
                        q = (vm*m + vv/2) / vv;
                        cneg = (v[i] < 0) != (d < 0);
                        lim = cneg ? 32768 : 32767;
                        if (q > lim) begin
                            q = lim;
                            sat = 1'b1;
                        end
                        o[i] = cneg ? -longint'(q) : longint'(q);
                    end
                end
            end
            OP_DOT: begin
                d = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
                r.zero = (d == 0);
                r.scalar = d <<< 8;
            end
            OP_CROSS: begin
                c[0] = u[1]*v[2] - u[2]*v[1];
                c[1] = u[2]*v[0] - u[0]*v[2];
                c[2] = u[0]*v[1] - u[1]*v[0];
                r.zero = (c[0] == 0 && c[1] == 0 && c[2] == 0);
                for (int i = 0; i < 3; i++) o[i] = clamp_coord(round_q8(c[i]), sat);
            end
            default: begin
                c[0] = v[1]*w[2] - v[2]*w[1];
                c[1] = v[2]*w[0] - v[0]*w[2];
                c[2] = v[0]*w[1] - v[1]*w[0];
                d = c[0]*u[0] + c[1]*u[1] + c[2]*u[2];
                r.zero = (d == 0);
                r.scalar = d;
            end
        endcase
        r.x = o[0][15:0];
        r.y = o[1][15:0];
        r.z = o[2][15:0];
        r.sat = sat;
        return r;
    endfunction

    // Queue a prediction per accepted item, check each accepted result
    always @(posedge i_clk) begin
        t_res exp_res;
        longint u[3];
        longint v[3];
        longint w[3];
        if (!i_rst_n) begin
            expected_q.delete();
        end else begin
            if (i_valid && !i_stall_in) begin
                u = '{i_u_x, i_u_y, i_u_z};
                v = '{i_v_x, i_v_y, i_v_z};
                w = '{i_w_x, i_w_y, i_w_z};
                expected_q.push_back(predict_vector_op(t_op'(i_req_type), u, v, w,
                                                       longint'(i_scale_factor)));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_res_x !== exp_res.x || i_res_y !== exp_res.y ||
                        i_res_z !== exp_res.z || i_res_scalar !== exp_res.scalar ||
                        i_is_zero !== exp_res.zero || i_status !== exp_res.status ||
                        i_saturated !== exp_res.sat) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_res_x !== exp_res.x)
                            $error("res_x exp %0d got %0d", exp_res.x, i_res_x);
                        if (i_res_y !== exp_res.y)
                            $error("res_y exp %0d got %0d", exp_res.y, i_res_y);
                        if (i_res_z !== exp_res.z)
                            $error("res_z exp %0d got %0d", exp_res.z, i_res_z);
                        if (i_res_scalar !== exp_res.scalar)
                            $error("res_scalar exp %0d got %0d", exp_res.scalar,
                                   i_res_scalar);
                        if (i_is_zero !== exp_res.zero)
                            $error("is_zero exp %0b got %0b", exp_res.zero, i_is_zero);
                        if (i_status !== exp_res.status)
                            $error("status exp %0b got %0b", exp_res.status, i_status);
                        if (i_saturated !== exp_res.sat)
                            $error("saturated exp %0b got %0b", exp_res.sat, i_saturated);
                    end
                end
            end
        end
        // Publish the count of items still waiting for a result
        o_pending <= expected_q.size();
    end

    initial o_fail_count = 0;

endmodule

`default_nettype wire

// ===== sim/tb_vector3_alu.sv =====
`default_nettype none

module tb_vector3_alu;
    import v3a_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic [2:0] i_req_type = '0;
    t_coord i_u_x = '0, i_u_y = '0, i_u_z = '0;
    t_coord i_v_x = '0, i_v_y = '0, i_v_z = '0;
    t_coord i_w_x = '0, i_w_y = '0, i_w_z = '0;
    t_coord i_scale_factor = '0;
    t_coord o_res_x, o_res_y, o_res_z;
    logic signed [SCALAR_W-1:0] o_res_scalar;
    logic o_is_zero, o_status, o_saturated;
    int fail_count;
    int pending;

    // Receiver behavior: idle percentage and long hold-off request
    int rx_idle_pct = 0;
    bit hold_off = 1'b0;

    always #10 i_clk = ~i_clk;

    vector3_alu dut (.*);

    vector3_alu_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_req_type,
        .i_u_x, .i_u_y, .i_u_z, .i_v_x, .i_v_y, .i_v_z, .i_w_x, .i_w_y, .i_w_z,
        .i_scale_factor, .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_res_x(o_res_x), .i_res_y(o_res_y), .i_res_z(o_res_z),
        .i_res_scalar(o_res_scalar), .i_is_zero(o_is_zero), .i_status(o_status),
        .i_saturated(o_saturated), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Drive the receiver stall
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
    end

    // Random coordinate: mostly full range, some extremes and small values
    function automatic t_coord rand_coord();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_coord'($urandom_range(16) - 8);
            3: return 16'sh0000;
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(t_op op, t_coord ux, t_coord uy, t_coord uz, t_coord vx,
                             t_coord vy, t_coord vz, t_coord wx, t_coord wy,
                             t_coord wz, t_coord sf, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= op;
        {i_u_x, i_u_y, i_u_z} <= {ux, uy, uz};
        {i_v_x, i_v_y, i_v_z} <= {vx, vy, vz};
        {i_w_x, i_w_y, i_w_z} <= {wx, wy, wz};
        i_scale_factor <= sf;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(int idle_pct);
        t_coord vx, vy, vz;
        vx = rand_coord();
        vy = rand_coord();
        vz = rand_coord();
        // Occasionally zero v to hit the projection error
        if ($urandom_range(15) == 0) {vx, vy, vz} = '0;
        send_item(t_op'($urandom_range(7)), rand_coord(), rand_coord(), rand_coord(),
                  vx, vy, vz, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  idle_pct);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_coord mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, special cases
        for (int op = 0; op < 8; op++) begin
            send_item(t_op'(op), mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, 0);
            send_item(t_op'(op), mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, 0);
        end
        send_item(OP_PROJ, 16'sh0100, 16'sh0200, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_DOT, 16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 0, 0, 0);
        send_item(OP_CROSS, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh0200, 16'sh0400,
                  16'sh0600, 0, 0, 0, 0, 0);
        send_item(OP_TRIPLE, 16'sh0100, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0);
        send_item(OP_SCALE, 16'sh0001, -16'sh0001, 16'sh0003, 0, 0, 0, 0, 0, 0,
                  16'sh0080, 0);
        send_item(OP_PROJ, 16'sh0003, 0, 0, 16'sh0002, 16'sh0002, 0, 0, 0, 0, 0, 0);
        send_item(OP_MAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // Sender idles lightly, receiver heavily
        rx_idle_pct = 51;
        repeat (300) send_random(9);

        // Long receiver hold-off while items keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (60) send_random(0);
        join

        // Sender pauses until everything has drained
        drain_results();

        rx_idle_pct = 9;
        repeat (260) send_random(51);
        rx_idle_pct = 0;
        repeat (260) send_random(0);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/v3a_pkg.sv
rtl/v3a_front.sv
rtl/v3a_iter.sv
rtl/v3a_back.sv
rtl/vector3_alu.sv
sim/vector3_alu_checker.sv
sim/tb_vector3_alu.sv
